[rtl/esrch_pkg.sv]
// Shared types, constants and defaults for the exponential search block.
package esrch_pkg;

  // Default sizes of the sorted store
  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths fixed by the interface
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Input word
  typedef struct packed {
    logic                    op;
    logic        [IDX_W-1:0] write_index;
    logic signed [VAL_W-1:0] elem_value;
    logic signed [VAL_W-1:0] search_key;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_word_t;

  // Outcome of one element/key compare
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

[rtl/esrch_mem.sv]
// Single-port-write, registered-read store of sorted elements.
module esrch_mem #(
  parameter int DEPTH      = esrch_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = esrch_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/esrch_cmp.sv]
// Shared signed compare unit: stored element against search key.
module esrch_cmp #(
  parameter int DATA_WIDTH = esrch_pkg::DATA_WIDTH_DEF
) (
  input  logic [DATA_WIDTH-1:0]              elem,
  input  logic signed [esrch_pkg::VAL_W-1:0] key,
  output esrch_pkg::cmp_t                    res
);
  import esrch_pkg::*;

  logic signed [DATA_WIDTH-1:0] elem_s;
  logic signed [63:0]           elem_x;
  logic signed [63:0]           key_x;

  // Sign-extend both sides to a common width
  assign elem_s = $signed(elem);
  assign elem_x = 64'(elem_s);
  assign key_x  = 64'(key);

  assign res.lt = (elem_x < key_x);
  assign res.eq = (elem_x == key_x);

endmodule

[rtl/esrch_seq.sv]
// Search sequencer: position-0 check, doubling phase, binary phase.
module esrch_seq #(
  parameter int DEPTH = esrch_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int PW    = AW + 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [esrch_pkg::VAL_W-1:0] start_key,
  input  logic [PW-1:0]                      count,
  input  esrch_pkg::cmp_t                    cmp,
  input  logic                               out_free,
  output logic                               idle,
  output logic signed [esrch_pkg::VAL_W-1:0] key,
  output logic [AW-1:0]                      rd_addr,
  output logic                               done,
  output esrch_pkg::out_word_t               res
);
  import esrch_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK0 = 5'b00010,
    S_DBL  = 5'b00100,
    S_BIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           p_r, p_nxt;
  logic [PW-1:0]           lo_r, lo_nxt;
  logic [PW-1:0]           hi_r, hi_nxt;
  logic [PW-1:0]           mid_r, mid_nxt;
  logic signed [VAL_W-1:0] key_r;
  out_word_t               res_r, res_nxt;

  logic [PW-1:0] n_m1;
  logic [PW-1:0] p2;
  logic [PW-1:0] pb, lo_b, hi_b, mid_b;
  logic [PW-1:0] lo_s, hi_s, mid_s;
  logic          empty_s;
  logic [31:0]   mid_ext;

  assign n_m1 = count - PW'(1);
  assign p2   = p_r << 1;

  // Bounds for the binary phase from the last probe
  always_comb begin
    if (state_r == S_DBL) begin
      pb = (cmp.lt || cmp.eq) ? p2 : p_r;
    end else begin
      pb = PW'(1);
    end
    lo_b  = pb >> 1;
    hi_b  = (pb < n_m1) ? pb : n_m1;
    mid_b = lo_b + ((hi_b - lo_b) >> 1);
  end

  // One binary step; range empties when the probe sits on the edge that does not move
  always_comb begin
    lo_s    = cmp.lt ? (mid_r + PW'(1)) : lo_r;
    hi_s    = cmp.lt ? hi_r : (mid_r - PW'(1));
    empty_s = cmp.lt ? (mid_r == hi_r) : (mid_r == lo_r);
    mid_s   = lo_s + ((hi_s - lo_s) >> 1);
  end

  assign mid_ext = 32'(mid_r);

  // Next state and read address
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    res_nxt   = res_r;
    rd_addr   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHK0;
        end
      end
      S_CHK0: begin
        if (cmp.eq) begin
          res_nxt   = '{found: 1'b1, position: '0};
          state_nxt = S_DONE;
        end else if (PW'(1) < count) begin
          p_nxt     = PW'(1);
          rd_addr   = AW'(1);
          state_nxt = S_DBL;
        end else begin
          lo_nxt    = lo_b;
          hi_nxt    = hi_b;
          mid_nxt   = mid_b;
          rd_addr   = mid_b[AW-1:0];
          state_nxt = S_BIN;
        end
      end
      S_DBL: begin
        if ((cmp.lt || cmp.eq) && (p2 < count)) begin
          p_nxt   = p2;
          rd_addr = p2[AW-1:0];
        end else begin
          lo_nxt    = lo_b;
          hi_nxt    = hi_b;
          mid_nxt   = mid_b;
          rd_addr   = mid_b[AW-1:0];
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        if (cmp.eq) begin
          res_nxt   = '{found: 1'b1, position: mid_ext[IDX_W-1:0]};
          state_nxt = S_DONE;
        end else if (empty_s) begin
          res_nxt   = '{found: 1'b0, position: '0};
          state_nxt = S_DONE;
        end else begin
          lo_nxt  = lo_s;
          hi_nxt  = hi_s;
          mid_nxt = mid_s;
          rd_addr = mid_s[AW-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    res_r <= res_nxt;
    if (start && state_r == S_IDLE) begin
      key_r <= start_key;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign key  = key_r;
  assign done = (state_r == S_DONE) && out_free;
  assign res  = res_r;

endmodule

[rtl/exponential_search.sv]
// Top level of the exponential search block over a sorted element store.
//
// Channels: in_valid/in_ready/in_data carry a word that either writes one
// element (op write) or searches for a key (op search). out_valid/out_ready/
// out_data return found and position, one word per search, none per write.
// cfg_valid/cfg_ready/cfg_data set the element count; cfg_ready is always
// high and the new count is used at once, also by a search in progress.
// Flow: a write is taken and in_ready stays high. A search checks entry 0,
// then makes doubling probes and then binary probes before its result is
// registered. The next word is taken only once the search has handed its
// result on and the sequencer is idle again, so searches do not overlap.
// While a search probes, the store gives one read per cycle through a
// single registered read port; in_ready is low while a search runs.
// Reset: the count returns to 1024 and the output is empty; stored elements
// are not cleared and must be written before they are searched.
// Stall: a result waits in the output register; a finished search holds
// until that register is free, and no new word is taken until then.
module exponential_search #(
  parameter int DEPTH      = esrch_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = esrch_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  esrch_pkg::in_word_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output esrch_pkg::out_word_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [esrch_pkg::COUNT_W-1:0]     cfg_data
);
  import esrch_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  logic [COUNT_W-1:0]    count_r;
  logic [31:0]           count_ext;
  logic [PW-1:0]         count_eff;
  logic                  out_valid_r;
  out_word_t             out_data_r;

  logic                  in_acc;
  logic                  wr_en;
  logic [31:0]           idx_ext;
  logic signed [63:0]    val_ext;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic signed [VAL_W-1:0] key;
  cmp_t                  cmp;
  logic                  idle;
  logic                  done;
  logic                  out_free;
  out_word_t             res;

  // Element count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_data;
    end
  end

  // Clamp the count to 1..DEPTH
  assign count_ext = 32'(count_r);
  always_comb begin
    if (count_ext == 32'd0) begin
      count_eff = PW'(1);
    end else if (count_ext > 32'(DEPTH)) begin
      count_eff = PW'(DEPTH);
    end else begin
      count_eff = count_ext[PW-1:0];
    end
  end

  // Input decode
  assign in_ready = idle;
  assign in_acc   = in_valid && in_ready;
  assign idx_ext  = 32'(in_data.write_index);
  assign val_ext  = 64'(in_data.elem_value);
  assign wr_en    = in_acc && (in_data.op == OP_WRITE) && (idx_ext < 32'(DEPTH));

  esrch_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (val_ext[DATA_WIDTH-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  esrch_cmp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cmp (
    .elem (rd_data),
    .key  (key),
    .res  (cmp)
  );

  esrch_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .PW    (PW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && (in_data.op == OP_SEARCH)),
    .start_key (in_data.search_key),
    .count     (count_eff),
    .cmp       (cmp),
    .out_free  (out_free),
    .idle      (idle),
    .key       (key),
    .rd_addr   (rd_addr),
    .done      (done),
    .res       (res)
  );

  // Output register
  assign out_free = !out_valid_r || out_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[dv/tb.sv]
// Testbench for the exponential search block: directed and random words, self-checking.
module tb;
  import esrch_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_WORDS = 200;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Mirror of the store and count, updated as words and writes are accepted
  logic signed [VAL_W-1:0] mirror_store [DEPTH_DEF];
  logic [COUNT_W-1:0] mirror_count = COUNT_RESET;
  out_word_t pending_results [$];

  int mismatches = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;

  exponential_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Count as the block uses it: 0 acts as 1, above the store size acts as full
  function automatic int used_entries(logic [COUNT_W-1:0] c);
    int n;
    n = c;
    if (n == 0) n = 1;
    if (n > DEPTH_DEF) n = DEPTH_DEF;
    return n;
  endfunction

  // Expected result of one search: check entry 0, double the probe, then bisect
  function automatic out_word_t lookup_key(logic signed [VAL_W-1:0] key);
    out_word_t r;
    int n, p, lo, hi, mid;
    r = '0;
    n = used_entries(mirror_count);
    if (mirror_store[0] == key) begin
      r.found = 1'b1;
      return r;
    end
    p = 1;
    while (p < n && mirror_store[p] <= key) p = p * 2;
    lo = p / 2;
    hi = (p < n - 1) ? p : n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mirror_store[mid] == key) begin
        r.found = 1'b1;
        r.position = IDX_W'(mid);
        return r;
      end
      if (mirror_store[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  // Key near the stored data: mostly hits, some neighbors, some anywhere
  function automatic logic signed [VAL_W-1:0] pick_key(int n);
    logic signed [VAL_W-1:0] k;
    k = mirror_store[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 9))
      6: k = k + 1;
      7: k = k - 1;
      8: k = $urandom;
      9: k = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      default: ;
    endcase
    return k;
  endfunction

  // Present one word, hold it until taken, then record what it should do
  task automatic send_word(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.op == OP_WRITE) mirror_store[w.write_index] = w.elem_value;
    else pending_results.push_back(lookup_key(w.search_key));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_word(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
    in_word_t w;
    w.op = OP_WRITE;
    w.write_index = idx;
    w.elem_value = val;
    w.search_key = $urandom;
    send_word(w);
  endtask

  task automatic search_word(logic signed [VAL_W-1:0] key);
    in_word_t w;
    w.op = OP_SEARCH;
    w.write_index = $urandom;
    w.elem_value = $urandom;
    w.search_key = key;
    send_word(w);
  endtask

  // Drop valid, let every search come back, then let trailing writes settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    mirror_count = value;
    cfg_valid <= 1'b0;
  endtask

  // Load entries 0..n-1 with ascending values, some repeated
  task automatic fill_sorted(int n, bit spread);
    int vals [$];
    int v;
    for (int i = 0; i < n; i++) begin
      if (spread) v = $urandom;
      else v = $urandom_range(0, 4 * n) - 2 * n;
      vals.push_back(v);
    end
    vals.sort();
    for (int i = 1; i < n; i++)
      if ($urandom_range(0, 7) == 0) vals[i] = vals[i-1];
    for (int i = 0; i < n; i++) write_word(IDX_W'(i), vals[i]);
  endtask

  // Count of 0 acts as one entry; extremes of the key against it
  task automatic test_single_entry();
    set_count('0);
    write_word('0, VAL_MIN);
    search_word(VAL_MIN);
    search_word(VAL_MAX);
    search_word('0);
    write_word('0, VAL_MAX);
    search_word(VAL_MAX);
    wait_idle();
  endtask

  // Four entries spanning the value range, misses, then an unsorted store
  task automatic test_small_extremes();
    set_count(COUNT_W'(4));
    write_word(IDX_W'(0), VAL_MIN);
    write_word(IDX_W'(1), -32'sd1);
    write_word(IDX_W'(2), 32'sd0);
    write_word(IDX_W'(3), VAL_MAX);
    search_word(VAL_MIN);
    search_word(-32'sd1);
    search_word(32'sd0);
    search_word(VAL_MAX);
    search_word(32'sd1);
    search_word(-32'sd2);
    // out of order: entry 1 above entry 2
    write_word(IDX_W'(1), VAL_MAX);
    search_word(32'sd0);
    search_word(VAL_MAX);
    wait_idle();
  endtask

  // Whole store in use, count over the top first, then exactly full
  task automatic test_full_store();
    set_count('1);
    fill_sorted(DEPTH_DEF, 1'b1);
    search_word(mirror_store[DEPTH_DEF-1]);
    search_word(mirror_store[0]);
    for (int i = 0; i < 20; i++) search_word(pick_key(DEPTH_DEF));
    wait_idle();
    set_count(COUNT_RESET);
    search_word(mirror_store[DEPTH_DEF-1]);
    for (int i = 0; i < 8; i++) search_word(pick_key(DEPTH_DEF));
    wait_idle();
  endtask

  // Phases: pick a count, reload sorted data unless the store is full, search, with stray writes mixed in
  task automatic test_random();
    int stop_at, sel, n, searches;
    logic [COUNT_W-1:0] cnt;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) cnt = '0;
      else if (sel == 1) cnt = COUNT_W'($urandom_range(DEPTH_DEF, 2047));
      else if (sel == 2) cnt = COUNT_W'($urandom_range(65, 300));
      else cnt = COUNT_W'($urandom_range(1, 64));
      no_gaps = ($urandom_range(0, 3) == 0);
      set_count(cnt);
      n = used_entries(cnt);
      if (n < DEPTH_DEF) fill_sorted(n, $urandom_range(0, 1));
      searches = $urandom_range(5, 30);
      for (int i = 0; i < searches; i++) begin
        if ($urandom_range(0, 9) == 0)
          write_word(IDX_W'($urandom_range(0, DEPTH_DEF - 1)), $urandom);
        else
          search_word(pick_key(n));
      end
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random backpressure, compare each word with the oldest expectation
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no search pending: found=%0b position=%0d",
                 $time, out_data.found, out_data.position);
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found || out_data.position !== want.position) begin
          mismatches++;
          $display({"%0t: result mismatch: expected found=%0b position=%0d, ",
                    "got found=%0b position=%0d"},
                   $time, want.found, want.position, out_data.found, out_data.position);
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("exponential_search test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_entry();
    test_small_extremes();
    test_full_store();
    test_random();
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("exponential_search test passed");
    else
      $display("exponential_search test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/esrch_pkg.sv
rtl/esrch_mem.sv
rtl/esrch_cmp.sv
rtl/esrch_seq.sv
rtl/exponential_search.sv
dv/tb.sv
